### rtl/rgbh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbh_pkg;

    localparam int CHAN_BITS = 8;
    localparam int OUT_BITS  = 24;
    localparam int NUM_CH    = 3;
    localparam int CH_RED    = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 2;

    localparam logic [OUT_BITS-1:0] OUT_MAX = 24'hFFFFFF;

    localparam logic [1:0] CMD_ACCUM     = 2'd0;
    localparam logic [1:0] CMD_READ      = 2'd1;
    localparam logic [1:0] CMD_NEW_IMAGE = 2'd2;

    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;
    localparam int QCNT_BITS  = 3;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] bin;
    } rgbh_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] red_count;
        logic [OUT_BITS-1:0] green_count;
        logic [OUT_BITS-1:0] blue_count;
        logic                is_gray;
    } rgbh_res_t;

    // One classified operation handed from the front to the back.
    typedef struct packed {
        logic                              is_read;
        logic                              in_range;
        logic                              gray;
        logic [NUM_CH-1:0][CHAN_BITS-1:0]  addr;
    } rgbh_op_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } rgbh_stat_t;

endpackage

`default_nettype wire

### rtl/rgbh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbh_front
    import rgbh_pkg::*;
#(
    parameter int NUM_BINS = 256
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  rgbh_in_t      item,
    output logic          full,
    input  wire logic     q_full,
    input  wire logic     clearing,
    output logic          enq,
    output rgbh_op_t      enq_op
);

    localparam logic [CHAN_BITS:0] BINS_W = (CHAN_BITS+1)'(NUM_BINS);
    localparam logic [CHAN_BITS:0] LAST_W = (CHAN_BITS+1)'(NUM_BINS - 1);

    logic gray_reg;
    logic gray_next;
    logic accept;

    function automatic logic [CHAN_BITS-1:0] bin_of(input logic [CHAN_BITS-1:0] v);
        logic [CHAN_BITS-1:0] r;
        r = ({1'b0, v} >= BINS_W) ? LAST_W[CHAN_BITS-1:0] : v;
        return r;
    endfunction

    assign full   = q_full || clearing;
    assign accept = push && !full;

    always_comb
    begin
        gray_next       = gray_reg;
        enq             = 1'b0;
        enq_op          = '0;
        enq_op.gray     = gray_reg;
        unique case (item.cmd)
            CMD_ACCUM:
            begin
                enq                  = accept;
                enq_op.addr[CH_RED]   = bin_of(item.red);
                enq_op.addr[CH_GREEN] = bin_of(item.green);
                enq_op.addr[CH_BLUE]  = bin_of(item.blue);
                if (accept && (item.red != item.green || item.red != item.blue))
                begin
                    gray_next = 1'b0;
                end
            end
            CMD_READ:
            begin
                enq                   = accept;
                enq_op.is_read        = 1'b1;
                enq_op.in_range       = ({1'b0, item.bin} < BINS_W);
                enq_op.addr[CH_RED]   = item.bin;
                enq_op.addr[CH_GREEN] = item.bin;
                enq_op.addr[CH_BLUE]  = item.bin;
            end
            CMD_NEW_IMAGE:
            begin
                if (accept)
                begin
                    gray_next = 1'b1;
                end
            end
            default:
            begin
                gray_next = gray_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg <= 1'b1;
        end
        else
        begin
            gray_reg <= gray_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rgbh_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbh_queue
    import rgbh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  rgbh_op_t  wr_op,
    output logic      q_full,
    input  wire logic rd,
    output logic      q_valid,
    output rgbh_op_t  rd_op
);

    rgbh_op_t             slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign q_full  = (count_reg == QCNT_BITS'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_op   = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rgbh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbh_back
    import rgbh_pkg::*;
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 24
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  rgbh_op_t   q_op,
    output logic       q_rd,
    output logic       empty,
    input  wire logic  pop,
    output rgbh_res_t  result,
    output rgbh_stat_t stat
);

    localparam int BIN_BITS = $clog2(NUM_BINS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                clr_active_reg;
    logic [BIN_BITS-1:0] clr_idx_reg;
    logic                b_valid_reg;
    rgbh_op_t            b_op_reg;
    logic                out_valid_reg;
    rgbh_res_t           out_reg;
    logic                out_free;
    logic                b_fire;
    logic                load_b;
    logic                b_write;

    logic [OUT_BITS-1:0] rpt [NUM_CH];

    assign out_free = !out_valid_reg || pop;
    assign b_fire   = b_valid_reg && (!b_op_reg.is_read || out_free);
    assign load_b   = q_valid && !clr_active_reg && (!b_valid_reg || b_fire);
    assign q_rd     = load_b;
    assign b_write  = b_fire && (!b_op_reg.is_read || b_op_reg.in_range);

    generate
        for (genvar c = 0; c < NUM_CH; c++)
        begin : g_chan
            logic [COUNT_BITS-1:0] mem [NUM_BINS];
            logic [COUNT_BITS-1:0] rdata_reg;
            logic                  lw_valid_reg;
            logic [BIN_BITS-1:0]   lw_addr_reg;
            logic [COUNT_BITS-1:0] lw_data_reg;
            logic [BIN_BITS-1:0]   b_addr;
            logic [COUNT_BITS-1:0] cur;
            logic [COUNT_BITS-1:0] new_cnt;
            logic [31:0]           cur_wide;
            logic                  wr_en;
            logic [BIN_BITS-1:0]   wr_addr;
            logic [COUNT_BITS-1:0] wr_data;

            assign b_addr = b_op_reg.addr[c][BIN_BITS-1:0];

            // The write of the previous operation lands on the same edge as this
            // operation's read, so the newest written count is forwarded.
            assign cur = (lw_valid_reg && lw_addr_reg == b_addr) ? lw_data_reg : rdata_reg;

            assign new_cnt = b_op_reg.is_read ? '0
                           : ((cur == CNT_MAX) ? cur : cur + 1'b1);

            assign cur_wide = 32'(cur);
            assign rpt[c]   = !b_op_reg.in_range ? '0
                            : ((cur_wide > 32'(OUT_MAX)) ? OUT_MAX : cur_wide[OUT_BITS-1:0]);

            assign wr_en   = clr_active_reg || b_write;
            assign wr_addr = clr_active_reg ? clr_idx_reg : b_addr;
            assign wr_data = clr_active_reg ? '0 : new_cnt;

            always_ff @(posedge clk)
            begin
                if (wr_en)
                begin
                    mem[wr_addr] <= wr_data;
                end
                if (load_b)
                begin
                    rdata_reg <= mem[q_op.addr[c][BIN_BITS-1:0]];
                end
                if (b_write)
                begin
                    lw_addr_reg <= b_addr;
                    lw_data_reg <= new_cnt;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    lw_valid_reg <= 1'b0;
                end
                else if (b_write)
                begin
                    lw_valid_reg <= 1'b1;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_op_reg <= q_op;
        end
        if (b_fire && b_op_reg.is_read)
        begin
            out_reg.red_count   <= rpt[CH_RED];
            out_reg.green_count <= rpt[CH_GREEN];
            out_reg.blue_count  <= rpt[CH_BLUE];
            out_reg.is_gray     <= b_op_reg.gray;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == BIN_BITS'(NUM_BINS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (load_b)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire && b_op_reg.is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty         = !out_valid_reg;
    assign result        = out_reg;
    assign stat.clearing = clr_active_reg;
    assign stat.busy     = b_valid_reg;

endmodule

`default_nettype wire

### rtl/rgb_pixel_histogram.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-channel 256-bin pixel histogram with saturating counters. A front stage
// decodes each beat, tracks the grayscale flag and files pixel and read operations
// into a four-entry queue; a back stage does a read-modify-write on the red, green
// and blue count memories, each with one write port and one registered read port,
// forwarding the last written count so that a pixel beat can follow every cycle.
// A sustained rate of one beat per clock is reached as long as read results are
// popped when shown; a read result goes through the queue and the back stage.
// After reset, full stays high while the memories are swept to zero,
// one row per cycle.
module rgb_pixel_histogram
    import rgbh_pkg::*;
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  rgbh_in_t  item,
    output logic      empty,
    input  wire logic pop,
    output rgbh_res_t result
);

    logic       q_full;
    logic       enq;
    rgbh_op_t   enq_op;
    logic       q_valid;
    logic       q_rd;
    rgbh_op_t   q_op;
    rgbh_stat_t stat;

    rgbh_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .q_full   (q_full),
        .clearing (stat.clearing),
        .enq      (enq),
        .enq_op   (enq_op)
    );

    rgbh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (enq),
        .wr_op   (enq_op),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_valid (q_valid),
        .rd_op   (q_op)
    );

    rgbh_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .stat    (stat)
    );

`ifndef SYNTH
    a_full_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> full)
        else $error("input accepted during the clearing sweep");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> (empty && !stat.busy && !q_valid))
        else $error("operation in flight during the clearing sweep");

    a_result_from_back: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(empty) && !empty) |-> $past(stat.busy))
        else $error("result appeared without an operation in the back stage");
`endif

endmodule

`default_nettype wire

### tb/rgb_pixel_histogram_tb.sv
`timescale 1ns / 1ps

module rgb_pixel_histogram_tb;
    import rgbh_pkg::*;

    localparam int NUM_BINS     = 256;
    localparam int COUNT_BITS   = 24;
    localparam int RANDOM_BEATS = 1120;
    localparam int CALM_BEATS   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;

    // The command code that the block has no use for.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class histogram_scoreboard;
        logic [COUNT_BITS-1:0] red_bins [NUM_BINS];
        logic [COUNT_BITS-1:0] green_bins [NUM_BINS];
        logic [COUNT_BITS-1:0] blue_bins [NUM_BINS];
        logic                  gray_so_far;
        rgbh_res_t             due_counts [$];
        int errors;
        int pixels;
        int readouts;
        int new_images;
        int unused_cmds;

        function new();
            foreach (red_bins[i])
            begin
                red_bins[i]   = '0;
                green_bins[i] = '0;
                blue_bins[i]  = '0;
            end
            gray_so_far = 1'b1;
            errors      = 0;
            pixels      = 0;
            readouts    = 0;
            new_images  = 0;
            unused_cmds = 0;
        endfunction

        // Levels past the last bin fold into it.
        function int bin_index(logic [CHAN_BITS-1:0] level);
            return (level >= NUM_BINS) ? NUM_BINS - 1 : int'(level);
        endfunction

        function logic [COUNT_BITS-1:0] bumped(logic [COUNT_BITS-1:0] c);
            return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
        endfunction

        function logic [OUT_BITS-1:0] clipped(logic [COUNT_BITS-1:0] c);
            logic [31:0] wide;
            wide = 32'(c);
            return (wide > 32'(OUT_MAX)) ? OUT_MAX : wide[OUT_BITS-1:0];
        endfunction

        function void note_beat(rgbh_in_t it);
            rgbh_res_t want;
            int        i;
            case (it.cmd)
                CMD_ACCUM:
                begin
                    i = bin_index(it.red);
                    red_bins[i] = bumped(red_bins[i]);
                    i = bin_index(it.green);
                    green_bins[i] = bumped(green_bins[i]);
                    i = bin_index(it.blue);
                    blue_bins[i] = bumped(blue_bins[i]);
                    if (it.red != it.green || it.red != it.blue)
                        gray_so_far = 1'b0;
                    pixels++;
                end
                CMD_READ:
                begin
                    want = '0;
                    if (it.bin < NUM_BINS)
                    begin
                        i = it.bin;
                        want.red_count   = clipped(red_bins[i]);
                        want.green_count = clipped(green_bins[i]);
                        want.blue_count  = clipped(blue_bins[i]);
                        red_bins[i]   = '0;
                        green_bins[i] = '0;
                        blue_bins[i]  = '0;
                    end
                    want.is_gray = gray_so_far;
                    due_counts.insert(due_counts.size(), want);
                end
                CMD_NEW_IMAGE:
                begin
                    gray_so_far = 1'b1;
                    new_images++;
                end
                default:
                    unused_cmds++;
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("%0t: readout mismatch: %s", $time, what);
        endtask

        task check_readout(rgbh_res_t got);
            rgbh_res_t want;
            if (due_counts.size() == 0)
            begin
                report($sformatf("unexpected readout r=%0d g=%0d b=%0d gray=%0b",
                                 got.red_count, got.green_count, got.blue_count,
                                 got.is_gray));
                return;
            end
            want = due_counts.pop_front();
            readouts++;
            if (got.red_count !== want.red_count)
                report($sformatf("red_count %0d, expected %0d",
                                 got.red_count, want.red_count));
            if (got.green_count !== want.green_count)
                report($sformatf("green_count %0d, expected %0d",
                                 got.green_count, want.green_count));
            if (got.blue_count !== want.blue_count)
                report($sformatf("blue_count %0d, expected %0d",
                                 got.blue_count, want.blue_count));
            if (got.is_gray !== want.is_gray)
                report($sformatf("is_gray %0b, expected %0b",
                                 got.is_gray, want.is_gray));
        endtask
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    rgbh_in_t  item  = '0;
    logic      full;
    logic      empty;
    rgbh_res_t result;

    histogram_scoreboard sb;
    logic calm         = 1'b0;
    int   hold_request = 0;

    always #4 clk = ~clk;

    rgb_pixel_histogram #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    function automatic rgbh_in_t beat_of(logic [1:0] cmd, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, logic [7:0] bin);
        rgbh_in_t it;
        it.cmd   = cmd;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        it.bin   = bin;
        return it;
    endfunction

    // Channel levels and read bins crowd into a few hot bins so that counts
    // build up before they are read back.
    function automatic logic [7:0] pick_level();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 8'($urandom_range(0, 7));
        else if (roll < 60)
            return 8'($urandom_range(248, 255));
        else
            return 8'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(rgbh_in_t it);
        item <= it;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full !== 1'b0);
        sb.note_beat(it);
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        push <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    initial
    begin : pop_driver
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else if (stall == 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 13);
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && empty === 1'b0)
            sb.check_readout(result);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && full === 1'b0) || (pop && empty === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        rgbh_in_t it;
        int       roll;
        logic     gray_run;
        logic [7:0] level;

        sb = new();
        gray_run = 1'b1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extreme levels, every command, ignored fields,
        // the unused command and the gray flag in both states.
        send_beat(beat_of(CMD_READ, 8'h5a, 8'ha5, 8'h3c, 8'd0));
        send_beat(beat_of(CMD_ACCUM, 8'd0, 8'd0, 8'd0, 8'hff));
        send_beat(beat_of(CMD_ACCUM, 8'd255, 8'd255, 8'd255, 8'd0));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd255));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(beat_of(CMD_ACCUM, 8'd255, 8'd0, 8'd170, 8'h55));
        send_beat(beat_of(CMD_READ, 8'hff, 8'hff, 8'hff, 8'd255));
        send_beat(beat_of(CMD_READ, 8'hff, 8'hff, 8'hff, 8'd0));
        send_beat(beat_of(CMD_READ, 8'hff, 8'hff, 8'hff, 8'd170));
        send_beat(beat_of(CMD_NEW_IMAGE, 8'hff, 8'h00, 8'hff, 8'hff));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(beat_of(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'd170));
        send_beat(beat_of(CMD_ACCUM, 8'd85, 8'd85, 8'd85, 8'd0));
        send_beat(beat_of(CMD_ACCUM, 8'd1, 8'd2, 8'd1, 8'd0));
        send_beat(beat_of(CMD_ACCUM, 8'd1, 8'd1, 8'd2, 8'd0));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd85));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd1));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd2));
        send_beat(beat_of(CMD_ACCUM, 8'd128, 8'd128, 8'd128, 8'd0));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd128));
        send_beat(beat_of(CMD_NEW_IMAGE, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(beat_of(CMD_ACCUM, 8'd128, 8'd128, 8'd128, 8'd0));
        send_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd128));

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            calm = (n >= RANDOM_BEATS - CALM_BEATS);
            if (n == RANDOM_BEATS / 2)
            begin
                // Hold the output side off while reads keep coming, so that the
                // result side backs up into the input.
                hold_request = HOLD_CYCLES;
                repeat (30)
                    send_beat(beat_of(CMD_READ, 8'($urandom), 8'($urandom),
                                      8'($urandom), pick_level()));
            end
            if (!calm && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 13));

            it.red   = 8'($urandom);
            it.green = 8'($urandom);
            it.blue  = 8'($urandom);
            it.bin   = 8'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 58)
            begin
                it.cmd = CMD_ACCUM;
                if (gray_run && $urandom_range(0, 19) != 0)
                begin
                    level    = pick_level();
                    it.red   = level;
                    it.green = level;
                    it.blue  = level;
                end
                else
                begin
                    it.red   = pick_level();
                    it.green = pick_level();
                    it.blue  = pick_level();
                end
            end
            else if (roll < 90)
            begin
                it.cmd = CMD_READ;
                it.bin = pick_level();
            end
            else if (roll < 96)
            begin
                it.cmd   = CMD_NEW_IMAGE;
                gray_run = 1'($urandom_range(0, 1));
            end
            else
            begin
                it.cmd = CMD_UNUSED;
            end
            send_beat(it);
        end
        push <= 1'b0;

        while (sb.due_counts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d pixel beats, %0d bin readouts, %0d new-image beats",
                 sb.pixels, sb.readouts, sb.new_images);
        $display("and %0d unused-command beats, with a long output hold-off.",
                 sb.unused_cmds);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
